FILE: sv/nkro_pkg.sv
// ----------------------------------------------------------------------------
// nkro_pkg
// Shared types and constants for the NKRO keyboard report builder.
// ----------------------------------------------------------------------------
package nkro_pkg;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 8;
    localparam int POS_W  = 6;
    localparam int BYTE_W = 8;

    localparam logic [KEY_W-1:0] MOD_FIRST = 8'hE0;
    localparam logic [KEY_W-1:0] MOD_LAST  = 8'hE7;

    typedef enum logic [OP_W-1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_SEND    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KRD,
        ST_KWR,
        ST_DECIDE,
        ST_SEND,
        ST_RESP
    } st_t;

endpackage

FILE: sv/nkro_key_report_builder_core.sv
// ----------------------------------------------------------------------------
// nkro_key_report_builder_core
// NKRO keyboard report builder with current and last-sent report memories.
// ----------------------------------------------------------------------------
// Input words on s_*: press, release, clear all, or send if changed. Byte 0 of
// the report holds modifier bits for keycodes 0xE0..0xE7, byte 1+(k>>3) holds
// bit k&7 for other keycodes. cfg_we/cfg_wdata write class_registered.
// Output words on m_*: when a changed report goes out (class registered, host
// accepts), REPORT_BYTES words carry bytes 0..REPORT_BYTES-1, tlast on the
// last; otherwise one status word with tlast set.
// One item at a time. Press/release take a read-modify-write of the current
// report memory (accept, read, write, decide states) before the result;
// clear, send and rejected keys go straight from accept to the decision. A
// single-word result then follows; a send streams one byte per cycle, while
// m_tready does not stall, out of the registered memory read port. Per-entry
// difference flags make the changed check a single OR, not a sweep.
// Reset: both reports read as zero (per-entry valid flags cleared), class not
// registered, output empty. A stall on m_tready holds the output word and
// pauses the byte stream; s_tready stays low until the item is done.
// ----------------------------------------------------------------------------
module nkro_key_report_builder_core
    import nkro_pkg::*;
#(
    parameter int REPORT_BYTES = 33
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_wdata,      // class_registered
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [1:0] operation, [9:2] keycode, [10] host_accepts
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,        // [0] key_accepted, [1] report_sent,
                                        // [7:2] byte_position, [15:8] report_byte
    output logic        m_tlast         // last_of_run
);

    localparam int ADDR_W = (REPORT_BYTES > 1) ? $clog2(REPORT_BYTES) : 1;
    localparam int CNT_W  = $clog2(REPORT_BYTES + 1);

    st_t state_reg, state_next;

    logic [BYTE_W-1:0] cur_mem  [REPORT_BYTES];
    logic [BYTE_W-1:0] sent_mem [REPORT_BYTES];

    logic [REPORT_BYTES-1:0] cur_vld_reg, sent_vld_reg;
    logic [REPORT_BYTES-1:0] diff_reg, cur_nz_reg, sent_nz_reg;

    logic              class_reg;
    op_t               op_reg;
    logic              acc_reg, ok_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [BYTE_W-1:0] mask_reg;

    logic [BYTE_W-1:0] cur_rd_reg, sent_rd_reg;
    logic              cur_rdv_reg, sent_rdv_reg;

    logic [CNT_W-1:0]  rd_cnt_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] pend_idx_reg;

    logic              m_tvalid_reg, m_tlast_reg;
    logic [15:0]       m_tdata_reg;

    // input decode
    op_t               in_op;
    logic [KEY_W-1:0]  in_code;
    logic              in_acc;
    logic              is_key;
    logic              dec_ok;
    logic [ADDR_W-1:0] dec_pos;
    logic [BYTE_W-1:0] dec_mask;
    logic [7:0]        idx_ext, pos_full;

    // control
    logic              s_acc, out_free, send_go, issue, mv;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] cur_byte, sent_byte, new_byte;

    assign in_op   = op_t'(s_tdata[1:0]);
    assign in_code = s_tdata[9:2];
    assign in_acc  = s_tdata[10];
    assign is_key  = (in_op == OP_PRESS) || (in_op == OP_RELEASE);
    assign idx_ext = {3'b000, in_code[7:3]};
    assign pos_full = idx_ext + 8'd1;

    always_comb begin
        dec_ok   = 1'b1;
        dec_pos  = '0;
        dec_mask = 8'(1) << in_code[2:0];
        if (in_code > MOD_LAST) begin
            dec_ok = 1'b0;
        end else if (in_code >= MOD_FIRST) begin
            dec_pos = '0;
        end else if (idx_ext >= 8'(REPORT_BYTES - 1)) begin
            dec_ok = 1'b0;
        end else begin
            dec_pos = pos_full[ADDR_W-1:0];
        end
    end

    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign send_go   = ok_reg && class_reg && acc_reg && (|diff_reg);
    assign cur_byte  = cur_rdv_reg ? cur_rd_reg : '0;
    assign sent_byte = sent_rdv_reg ? sent_rd_reg : '0;
    assign new_byte  = (op_reg == OP_PRESS) ? (cur_byte | mask_reg) : (cur_byte & ~mask_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = (is_key && dec_ok) ? ST_KRD : ST_DECIDE;
                end
            end
            ST_KRD:    state_next = ST_KWR;
            ST_KWR:    state_next = ST_DECIDE;
            ST_DECIDE: state_next = send_go ? ST_SEND : ST_RESP;
            ST_SEND: begin
                if (mv && (pend_idx_reg == ADDR_W'(REPORT_BYTES - 1))) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = pos_reg;
        issue    = 1'b0;
        mv       = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_KRD:  rd_en = 1'b1;
            ST_SEND: begin
                mv      = pend_reg && out_free;
                issue   = (!pend_reg || mv) && (rd_cnt_reg < CNT_W'(REPORT_BYTES));
                rd_en   = issue;
                rd_addr = rd_cnt_reg[ADDR_W-1:0];
            end
            default: ;
        endcase
    end

    // report memories
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cur_rd_reg  <= cur_mem[rd_addr];
            sent_rd_reg <= sent_mem[rd_addr];
        end
        if (state_reg == ST_KWR) begin
            cur_mem[pos_reg] <= new_byte;
        end
        if (mv) begin
            sent_mem[pend_idx_reg] <= cur_byte;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cur_rdv_reg  <= cur_vld_reg[rd_addr];
            sent_rdv_reg <= sent_vld_reg[rd_addr];
        end
        if (s_acc) begin
            op_reg   <= in_op;
            acc_reg  <= in_acc;
            ok_reg   <= is_key ? dec_ok : 1'b1;
            pos_reg  <= dec_pos;
            mask_reg <= dec_mask;
        end
        if (state_reg == ST_SEND && issue) begin
            pend_idx_reg <= rd_cnt_reg[ADDR_W-1:0];
        end
        if (mv) begin
            m_tdata_reg <= {cur_byte, POS_W'(pend_idx_reg), 1'b1, 1'b1};
            m_tlast_reg <= (pend_idx_reg == ADDR_W'(REPORT_BYTES - 1));
        end else if (state_reg == ST_RESP && out_free) begin
            m_tdata_reg <= {15'd0, ok_reg};
            m_tlast_reg <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            class_reg    <= 1'b0;
            cur_vld_reg  <= '0;
            sent_vld_reg <= '0;
            diff_reg     <= '0;
            cur_nz_reg   <= '0;
            sent_nz_reg  <= '0;
            rd_cnt_reg   <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                class_reg <= cfg_wdata[0];
            end
            if (s_acc && in_op == OP_CLEAR) begin
                cur_vld_reg <= '0;
                cur_nz_reg  <= '0;
                diff_reg    <= sent_nz_reg;
            end
            if (state_reg == ST_KWR) begin
                cur_vld_reg[pos_reg] <= 1'b1;
                cur_nz_reg[pos_reg]  <= (new_byte != '0);
                diff_reg[pos_reg]    <= (new_byte != sent_byte);
            end
            if (state_reg == ST_DECIDE && send_go) begin
                sent_nz_reg <= cur_nz_reg;
                diff_reg    <= '0;
                rd_cnt_reg  <= '0;
                pend_reg    <= 1'b0;
            end
            if (state_reg == ST_SEND) begin
                if (issue) begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                    pend_reg   <= 1'b1;
                end else if (mv) begin
                    pend_reg <= 1'b0;
                end
                if (mv) begin
                    sent_vld_reg[pend_idx_reg] <= 1'b1;
                end
            end
            if (mv || (state_reg == ST_RESP && out_free)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: sv/nkro_checker.sv
// ----------------------------------------------------------------------------
// nkro_checker
// Port-level checks for the NKRO keyboard report builder.
// ----------------------------------------------------------------------------
module nkro_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tlast && (m_tdata[15:2] == 14'd0))
        else $error("status word not single and clean");

    a_sent_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("sent byte without key accepted");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

endmodule

bind nkro_key_report_builder_core nkro_checker u_nkro_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
